// ===== src/hlgt_pkg.sv =====
package hlgt_pkg;

  // Fixed sizes of the landmark set and of the configuration port
  localparam int NUM_POINTS    = 21;
  localparam int COORD_BITS_DEF = 14;
  localparam int POINT_IDX_W   = 5;
  localparam int CFG_IDX_W     = 3;
  localparam int CFG_DATA_W    = 12;
  localparam int DIM_W         = 12;
  localparam int RADIUS_W      = 14;
  localparam int FINGER_W      = 3;
  localparam int MISS_W        = 8;
  localparam int WEIGHT_W      = 4;

  // Reset values of the configuration registers
  localparam logic [DIM_W-1:0]    FRAME_W_RST  = 12'd640;
  localparam logic [DIM_W-1:0]    FRAME_H_RST  = 12'd480;
  localparam logic [WEIGHT_W-1:0] WEIGHT_RST   = 4'd3;
  localparam logic [MISS_W-1:0]   MISS_LIM_RST = 8'd3;
  localparam logic [DIM_W-1:0]    MIN_SPAN_RST = 12'd20;
  localparam logic [WEIGHT_W-1:0] WEIGHT_MAX   = 4'd10;
  localparam logic [MISS_W-1:0]   MISS_MAX     = 8'd255;
  localparam logic [RADIUS_W-1:0] RADIUS_MAX   = 14'd16383;

  // Reciprocal constants: x/10 = (x*DIV10_MUL) >> DIV10_SHIFT, x/5 likewise
  localparam logic [19:0] DIV10_MUL   = 20'hCCCCD;
  localparam int          DIV10_SHIFT = 23;
  localparam logic [15:0] DIV5_MUL    = 16'hCCCD;
  localparam int          DIV5_SHIFT  = 18;

  // Number of squared-difference steps in the finish pass
  localparam int SQ_STEPS = 6;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_W  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_H  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WEIGHT   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MISS_LIM = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_SPAN = 3'd4;

  // Item function codes
  typedef enum logic [1:0] {
    FUNC_POINT   = 2'd0,
    FUNC_NO_HAND = 2'd1,
    FUNC_FAILED  = 2'd2,
    FUNC_UNUSED  = 2'd3
  } func_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_READ,
    ST_MUL,
    ST_WRITE,
    ST_SWEEP,
    ST_SQ,
    ST_GEST,
    ST_SQRT,
    ST_PAD,
    ST_OUT
  } state_e;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load;
    logic clear;
    logic miss_inc;
    logic rd_point;
    logic mul;
    logic wr_point;
    logic sweep_init;
    logic sweep;
    logic sq_init;
    logic sq_step;
    logic gesture;
    logic sqrt_step;
    logic pad;
    logic out_load;
  } cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic last;
    logic sweep_done;
    logic sq_done;
    logic erase_now;
    logic sqrt_done;
    logic out_free;
  } stat_t;

endpackage

// ===== src/hlgt_ctrl.sv =====
module hlgt_ctrl
  import hlgt_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  func_i,
  input  stat_t       stat_i,
  output cmd_t        cmd_o
);

  state_e state_q, state_d;
  logic   accept;

  assign in_stall_o = (state_q != ST_IDLE);
  assign accept     = in_valid_i && (state_q == ST_IDLE);

  // Advance the sequencer
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          case (func_e'(func_i))
            FUNC_POINT:   state_d = ST_READ;
            FUNC_NO_HAND: state_d = ST_PAD;
            FUNC_FAILED:  state_d = ST_PAD;
            default:      state_d = ST_IDLE;
          endcase
        end
      end
      ST_READ:  state_d = ST_MUL;
      ST_MUL:   state_d = ST_WRITE;
      ST_WRITE: state_d = stat_i.last ? ST_SWEEP : ST_IDLE;
      ST_SWEEP: if (stat_i.sweep_done) state_d = ST_SQ;
      ST_SQ:    if (stat_i.sq_done) state_d = ST_GEST;
      ST_GEST:  state_d = stat_i.erase_now ? ST_SQRT : ST_PAD;
      ST_SQRT:  if (stat_i.sqrt_done) state_d = ST_PAD;
      ST_PAD:   state_d = ST_OUT;
      ST_OUT:   if (stat_i.out_free) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // Drive datapath commands
  always_comb begin
    cmd_o = '0;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          cmd_o.load = 1'b1;
          case (func_e'(func_i))
            FUNC_NO_HAND: cmd_o.clear    = 1'b1;
            FUNC_FAILED:  cmd_o.miss_inc = 1'b1;
            default:      cmd_o.load     = 1'b1;
          endcase
        end
      end
      ST_READ:  cmd_o.rd_point = 1'b1;
      ST_MUL:   cmd_o.mul = 1'b1;
      ST_WRITE: begin
        cmd_o.wr_point   = 1'b1;
        cmd_o.sweep_init = stat_i.last;
      end
      ST_SWEEP: begin
        cmd_o.sweep   = 1'b1;
        cmd_o.sq_init = stat_i.sweep_done;
      end
      ST_SQ:    cmd_o.sq_step = 1'b1;
      ST_GEST:  cmd_o.gesture = 1'b1;
      ST_SQRT:  cmd_o.sqrt_step = 1'b1;
      ST_PAD:   cmd_o.pad = 1'b1;
      ST_OUT:   cmd_o.out_load = stat_i.out_free;
      default:  cmd_o = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== src/hlgt_dpath.sv =====
module hlgt_dpath
  import hlgt_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [CFG_IDX_W-1:0]          cfg_index_i,
  input  logic [CFG_DATA_W-1:0]         cfg_data_i,
  input  logic [POINT_IDX_W-1:0]        point_index_i,
  input  logic signed [COORD_BITS-1:0]  point_x_i,
  input  logic signed [COORD_BITS-1:0]  point_y_i,
  input  logic                          last_i,
  input  cmd_t                          cmd_i,
  output stat_t                         stat_o,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic                          hand_detected_o,
  output logic                          painting_o,
  output logic                          erasing_o,
  output logic [FINGER_W-1:0]           finger_count_o,
  output logic signed [COORD_BITS-1:0]  eraser_x_o,
  output logic signed [COORD_BITS-1:0]  eraser_y_o,
  output logic [RADIUS_W-1:0]           eraser_radius_o,
  output logic                          track_valid_o,
  output logic [DIM_W-1:0]              search_x_o,
  output logic [DIM_W-1:0]              search_y_o,
  output logic [DIM_W-1:0]              search_w_o,
  output logic [DIM_W-1:0]              search_h_o
);

  localparam int CB    = COORD_BITS;
  localparam int SW    = CB + 5;
  localparam int PW    = SW + 20;
  localparam int DW    = 2 * CB + 2;
  localparam int EW    = ((CB > DIM_W + 1) ? CB : DIM_W + 1) + 1;
  localparam int IDXW  = $clog2(NUM_POINTS);
  localparam int SQRT_STEPS = DW / 2;
  localparam int CNT_MAX = (NUM_POINTS > SQRT_STEPS) ? NUM_POINTS : SQRT_STEPS;
  localparam int CNTW  = $clog2(CNT_MAX + 1);

  // Configuration registers
  logic [DIM_W-1:0]    cfg_w_q, cfg_h_q, cfg_span_q;
  logic [WEIGHT_W-1:0] cfg_wt_q;
  logic [MISS_W-1:0]   cfg_lim_q;

  // Item and point store
  logic [POINT_IDX_W-1:0]  idx_q;
  logic signed [CB-1:0]    x_q, y_q;
  logic                    last_q;
  logic signed [CB-1:0]    mem_x [NUM_POINTS];
  logic signed [CB-1:0]    mem_y [NUM_POINTS];
  logic signed [CB-1:0]    rd_x_q, rd_y_q;
  logic [IDXW-1:0]         rd_idx_q;
  logic                    rd_vld_q;
  logic [NUM_POINTS-1:0]   valid_q;
  logic                    idx_ok;
  logic                    mem_re, mem_we;
  logic [IDXW-1:0]         mem_raddr;

  // Tracking state
  logic [MISS_W-1:0]    miss_q, miss_sat;
  logic                 det_q, paint_q, erase_q, box_v_q;
  logic [FINGER_W-1:0]  fing_q;
  logic signed [CB-1:0] ctr_x_q, ctr_y_q;
  logic [RADIUS_W-1:0]  size_q;
  logic [DIM_W-1:0]     bx_q, by_q, bw_q, bh_q;
  logic [DIM_W-1:0]     mnx_q, mxx_q, mny_q, mxy_q;

  // Smoothing datapath
  logic [WEIGHT_W-1:0]  w_eff, w_new;
  logic signed [SW-1:0] wo_s, wn_s, ema_x, ema_y;
  logic signed [SW-1:0] sum_x_q, sum_y_q;
  logic                 take_q;
  logic [SW-1:0]        mag_x, mag_y;
  logic [PW-1:0]        prod_x, prod_y;
  logic [CB:0]          quo_x, quo_y;
  logic signed [CB-1:0] new_x, new_y, wr_x, wr_y;

  // Finish pass
  logic [CNTW-1:0]      cnt_q;
  logic signed [CB-1:0] cx_q [5];
  logic signed [CB-1:0] cy_q [5];
  logic signed [CB-1:0] fy_q [8];
  logic                 rd_pt_ok;
  logic signed [CB-1:0] vx, vy;
  logic signed [EW-1:0] wm1, hm1, cl_x1, cl_y1;
  logic [DIM_W-1:0]     tx, ty;
  logic signed [CB-1:0] sq_a, sq_b;
  logic signed [CB:0]   sq_diff;
  logic signed [DW-1:0] sq_prod;
  logic [DW-1:0]        d42_q, d32_q, d09_q;
  logic [DW+4:0]        thumb_l, thumb_r;
  logic                 thumb, ind_up, mid_up, ring_up, pinky_up, down3, erase_now;
  logic [DW-1:0]        rem_q, root_q, bit_q, trial;
  logic [DW-1:0]        half_root, root_nxt, radius_nxt;

  // Search region
  logic [DIM_W-1:0]     padx_q, pady_q;
  logic [29:0]          padx_p, pady_p;
  logic signed [DIM_W+2:0] sx_s, sy_s, avail_w, avail_h, ext_w, ext_h, sw_s, sh_s;
  logic [DIM_W-1:0]     sx_c, sy_c;

  // Output register
  logic                 out_valid_q;

  // Write configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_w_q    <= FRAME_W_RST;
      cfg_h_q    <= FRAME_H_RST;
      cfg_wt_q   <= WEIGHT_RST;
      cfg_lim_q  <= MISS_LIM_RST;
      cfg_span_q <= MIN_SPAN_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_FRAME_W:  cfg_w_q    <= cfg_data_i[DIM_W-1:0];
        CFG_FRAME_H:  cfg_h_q    <= cfg_data_i[DIM_W-1:0];
        CFG_WEIGHT:   cfg_wt_q   <= cfg_data_i[WEIGHT_W-1:0];
        CFG_MISS_LIM: cfg_lim_q  <= cfg_data_i[MISS_W-1:0];
        CFG_MIN_SPAN: cfg_span_q <= cfg_data_i[DIM_W-1:0];
        default:      cfg_w_q    <= cfg_w_q;
      endcase
    end
  end

  // Latch the accepted item
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      idx_q  <= point_index_i;
      x_q    <= point_x_i;
      y_q    <= point_y_i;
      last_q <= last_i;
    end
  end

  assign idx_ok = (idx_q < POINT_IDX_W'(NUM_POINTS));

  // Point store: one read port, one write port
  assign mem_re    = cmd_i.rd_point || (cmd_i.sweep && (cnt_q < CNTW'(NUM_POINTS)));
  assign mem_raddr = cmd_i.rd_point ? idx_q[IDXW-1:0] : cnt_q[IDXW-1:0];
  assign mem_we    = cmd_i.wr_point && idx_ok;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_x[idx_q[IDXW-1:0]] <= wr_x;
      mem_y[idx_q[IDXW-1:0]] <= wr_y;
    end
    if (mem_re) begin
      rd_x_q   <= mem_x[mem_raddr];
      rd_y_q   <= mem_y[mem_raddr];
      rd_idx_q <= mem_raddr;
    end
  end

  // Weighted sum of old and new point
  assign w_eff = (cfg_wt_q > WEIGHT_MAX) ? WEIGHT_MAX : cfg_wt_q;
  assign w_new = WEIGHT_MAX - w_eff;
  assign wo_s  = SW'($signed({1'b0, w_eff}));
  assign wn_s  = SW'($signed({1'b0, w_new}));
  assign ema_x = wo_s * SW'(rd_x_q) + wn_s * SW'(x_q);
  assign ema_y = wo_s * SW'(rd_y_q) + wn_s * SW'(y_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul) begin
      sum_x_q <= ema_x;
      sum_y_q <= ema_y;
      take_q  <= (miss_q != '0) || !(idx_ok && valid_q[idx_q[IDXW-1:0]]);
    end
  end

  // Divide by ten, truncated toward zero
  assign mag_x  = sum_x_q[SW-1] ? SW'(-sum_x_q) : SW'(sum_x_q);
  assign mag_y  = sum_y_q[SW-1] ? SW'(-sum_y_q) : SW'(sum_y_q);
  assign prod_x = PW'(mag_x) * PW'(DIV10_MUL);
  assign prod_y = PW'(mag_y) * PW'(DIV10_MUL);
  assign quo_x  = prod_x[DIV10_SHIFT +: CB+1];
  assign quo_y  = prod_y[DIV10_SHIFT +: CB+1];
  assign new_x  = sum_x_q[SW-1] ? CB'(-quo_x) : CB'(quo_x);
  assign new_y  = sum_y_q[SW-1] ? CB'(-quo_y) : CB'(quo_y);
  assign wr_x   = take_q ? x_q : new_x;
  assign wr_y   = take_q ? y_q : new_y;

  // Clamp the swept point into the frame
  assign rd_pt_ok = valid_q[rd_idx_q];
  assign vx    = rd_pt_ok ? rd_x_q : '0;
  assign vy    = rd_pt_ok ? rd_y_q : '0;
  assign wm1   = EW'($signed({1'b0, cfg_w_q})) - EW'(1);
  assign hm1   = EW'($signed({1'b0, cfg_h_q})) - EW'(1);
  assign cl_x1 = (EW'(rd_x_q) > wm1) ? wm1 : EW'(rd_x_q);
  assign cl_y1 = (EW'(rd_y_q) > hm1) ? hm1 : EW'(rd_y_q);
  assign tx    = cl_x1[EW-1] ? '0 : cl_x1[DIM_W-1:0];
  assign ty    = cl_y1[EW-1] ? '0 : cl_y1[DIM_W-1:0];

  // Squared differences, one product a cycle
  always_comb begin
    sq_a = '0;
    sq_b = '0;
    case (cnt_q)
      CNTW'(0): begin sq_a = cx_q[3]; sq_b = cx_q[1]; end
      CNTW'(1): begin sq_a = cy_q[3]; sq_b = cy_q[1]; end
      CNTW'(2): begin sq_a = cx_q[2]; sq_b = cx_q[1]; end
      CNTW'(3): begin sq_a = cy_q[2]; sq_b = cy_q[1]; end
      CNTW'(4): begin sq_a = cx_q[0]; sq_b = cx_q[4]; end
      CNTW'(5): begin sq_a = cy_q[0]; sq_b = cy_q[4]; end
      default: begin sq_a = '0; sq_b = '0; end
    endcase
  end
  assign sq_diff = (CB+1)'(sq_a) - (CB+1)'(sq_b);
  assign sq_prod = DW'(sq_diff) * DW'(sq_diff);

  // Gesture decisions from captured points
  assign thumb_l   = (DW+5)'(d42_q) * (DW+5)'(25);
  assign thumb_r   = (DW+5)'(d32_q) * (DW+5)'(16);
  assign thumb     = thumb_l > thumb_r;
  assign ind_up    = fy_q[1] < fy_q[0];
  assign mid_up    = fy_q[3] < fy_q[2];
  assign ring_up   = fy_q[5] < fy_q[4];
  assign pinky_up  = fy_q[7] < fy_q[6];
  assign down3     = (fy_q[3] > fy_q[2]) && (fy_q[5] > fy_q[4]) && (fy_q[7] > fy_q[6]);
  assign erase_now = !ind_up && down3;

  // Integer square root, one result bit a cycle
  assign trial      = root_q + bit_q;
  assign half_root  = root_q >> 1;
  assign root_nxt   = (rem_q >= trial) ? half_root + bit_q : half_root;
  assign radius_nxt = root_nxt >> 1;

  // Sweep, squares, gesture and square root sequencing
  always_ff @(posedge clk_i) begin
    if (cmd_i.sweep_init) begin
      cnt_q <= '0;
    end else if (cmd_i.sq_init || cmd_i.gesture) begin
      cnt_q <= '0;
    end else if (cmd_i.sweep || cmd_i.sq_step || cmd_i.sqrt_step) begin
      cnt_q <= cnt_q + CNTW'(1);
    end

    if (cmd_i.sweep_init) begin
      rd_vld_q <= 1'b0;
    end else if (cmd_i.sweep) begin
      rd_vld_q <= (cnt_q < CNTW'(NUM_POINTS));
    end

    // Capture the points that the gesture tests need
    if (cmd_i.sweep && rd_vld_q) begin
      case (rd_idx_q)
        IDXW'(0):  begin cx_q[0] <= vx; cy_q[0] <= vy; end
        IDXW'(2):  begin cx_q[1] <= vx; cy_q[1] <= vy; end
        IDXW'(3):  begin cx_q[2] <= vx; cy_q[2] <= vy; end
        IDXW'(4):  begin cx_q[3] <= vx; cy_q[3] <= vy; end
        IDXW'(9):  begin cx_q[4] <= vx; cy_q[4] <= vy; end
        IDXW'(6):  fy_q[0] <= vy;
        IDXW'(8):  fy_q[1] <= vy;
        IDXW'(10): fy_q[2] <= vy;
        IDXW'(12): fy_q[3] <= vy;
        IDXW'(14): fy_q[4] <= vy;
        IDXW'(16): fy_q[5] <= vy;
        IDXW'(18): fy_q[6] <= vy;
        IDXW'(20): fy_q[7] <= vy;
        default:   fy_q[0] <= fy_q[0];
      endcase
    end

    // Accumulate squared distances
    if (cmd_i.sq_init) begin
      d42_q <= '0;
      d32_q <= '0;
      d09_q <= '0;
    end else if (cmd_i.sq_step) begin
      case (cnt_q)
        CNTW'(0), CNTW'(1): d42_q <= d42_q + DW'(sq_prod);
        CNTW'(2), CNTW'(3): d32_q <= d32_q + DW'(sq_prod);
        CNTW'(4), CNTW'(5): d09_q <= d09_q + DW'(sq_prod);
        default:            d09_q <= d09_q;
      endcase
    end

    if (cmd_i.gesture) begin
      rem_q  <= d09_q;
      root_q <= '0;
      bit_q  <= DW'(1) << (DW - 2);
    end else if (cmd_i.sqrt_step) begin
      if (rem_q >= trial) begin
        rem_q <= rem_q - trial;
      end
      root_q <= root_nxt;
      bit_q  <= bit_q >> 2;
    end
  end

  // Saturating miss count
  assign miss_sat = (miss_q == MISS_MAX) ? MISS_MAX : miss_q + MISS_W'(1);

  // Tracking state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      miss_q  <= '0;
      det_q   <= 1'b0;
      paint_q <= 1'b0;
      erase_q <= 1'b0;
      box_v_q <= 1'b0;
      fing_q  <= '0;
      ctr_x_q <= '0;
      ctr_y_q <= '0;
      size_q  <= '0;
      bx_q    <= '0;
      by_q    <= '0;
      bw_q    <= '0;
      bh_q    <= '0;
      mnx_q   <= '0;
      mxx_q   <= '0;
      mny_q   <= '0;
      mxy_q   <= '0;
    end else begin
      if (cmd_i.clear || (cmd_i.miss_inc && (miss_sat > cfg_lim_q))) begin
        valid_q <= '0;
        det_q   <= 1'b0;
        paint_q <= 1'b0;
        erase_q <= 1'b0;
        box_v_q <= 1'b0;
      end
      if (cmd_i.miss_inc) begin
        miss_q <= miss_sat;
      end
      if (mem_we) begin
        valid_q[idx_q[IDXW-1:0]] <= 1'b1;
      end

      // Grow the bounding extent over valid points
      if (cmd_i.sweep_init) begin
        mnx_q <= cfg_w_q;
        mxx_q <= '0;
        mny_q <= cfg_h_q;
        mxy_q <= '0;
      end else if (cmd_i.sweep && rd_vld_q && rd_pt_ok) begin
        if (tx < mnx_q) mnx_q <= tx;
        if (tx > mxx_q) mxx_q <= tx;
        if (ty < mny_q) mny_q <= ty;
        if (ty > mxy_q) mxy_q <= ty;
      end

      // Finish the frame
      if (cmd_i.gesture) begin
        miss_q  <= '0;
        det_q   <= 1'b1;
        fing_q  <= FINGER_W'(thumb) + FINGER_W'(ind_up) + FINGER_W'(mid_up)
                 + FINGER_W'(ring_up) + FINGER_W'(pinky_up);
        paint_q <= ind_up && down3;
        erase_q <= erase_now;
        if (erase_now) begin
          ctr_x_q <= cx_q[4];
          ctr_y_q <= cy_q[4];
        end else begin
          size_q <= '0;
        end
        if ((mxx_q > mnx_q) && (mxy_q > mny_q) && ((mxx_q - mnx_q) > cfg_span_q)) begin
          bx_q    <= mnx_q;
          by_q    <= mny_q;
          bw_q    <= mxx_q - mnx_q;
          bh_q    <= mxy_q - mny_q;
          box_v_q <= 1'b1;
        end else begin
          box_v_q <= 1'b0;
        end
      end

      // Half the final root, saturated
      if (cmd_i.sqrt_step && (cnt_q == CNTW'(SQRT_STEPS - 1))) begin
        if (radius_nxt > DW'(RADIUS_MAX)) begin
          size_q <= RADIUS_MAX;
        end else begin
          size_q <= radius_nxt[RADIUS_W-1:0];
        end
      end
    end
  end

  // Padding of four fifths of the box span
  assign padx_p = 30'({bw_q, 2'b00}) * 30'(DIV5_MUL);
  assign pady_p = 30'({bh_q, 2'b00}) * 30'(DIV5_MUL);

  always_ff @(posedge clk_i) begin
    if (cmd_i.pad) begin
      padx_q <= padx_p[DIV5_SHIFT +: DIM_W];
      pady_q <= pady_p[DIV5_SHIFT +: DIM_W];
    end
  end

  // Search region clamped into the frame
  assign sx_s    = (DIM_W+3)'({1'b0, bx_q}) - (DIM_W+3)'({1'b0, padx_q});
  assign sy_s    = (DIM_W+3)'({1'b0, by_q}) - (DIM_W+3)'({1'b0, pady_q});
  assign sx_c    = sx_s[DIM_W+2] ? '0 : sx_s[DIM_W-1:0];
  assign sy_c    = sy_s[DIM_W+2] ? '0 : sy_s[DIM_W-1:0];
  assign avail_w = (DIM_W+3)'({1'b0, cfg_w_q}) - (DIM_W+3)'({1'b0, sx_c});
  assign avail_h = (DIM_W+3)'({1'b0, cfg_h_q}) - (DIM_W+3)'({1'b0, sy_c});
  assign ext_w   = (DIM_W+3)'({1'b0, bw_q}) + (DIM_W+3)'({1'b0, padx_q, 1'b0});
  assign ext_h   = (DIM_W+3)'({1'b0, bh_q}) + (DIM_W+3)'({1'b0, pady_q, 1'b0});
  assign sw_s    = (avail_w < ext_w) ? avail_w : ext_w;
  assign sh_s    = (avail_h < ext_h) ? avail_h : ext_h;

  // Output register: hold until taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      hand_detected_o <= det_q;
      painting_o      <= det_q && paint_q;
      erasing_o       <= det_q && erase_q;
      finger_count_o  <= fing_q;
      eraser_x_o      <= ctr_x_q;
      eraser_y_o      <= ctr_y_q;
      eraser_radius_o <= (det_q && erase_q) ? size_q : '0;
      track_valid_o   <= box_v_q;
      search_x_o      <= box_v_q ? sx_c : '0;
      search_y_o      <= box_v_q ? sy_c : '0;
      search_w_o      <= (box_v_q && !sw_s[DIM_W+2]) ? sw_s[DIM_W-1:0] : '0;
      search_h_o      <= (box_v_q && !sh_s[DIM_W+2]) ? sh_s[DIM_W-1:0] : '0;
    end
  end

  assign out_valid_o = out_valid_q;

  // Status to the controller
  assign stat_o.last       = last_q;
  assign stat_o.sweep_done = (cnt_q == CNTW'(NUM_POINTS));
  assign stat_o.sq_done    = (cnt_q == CNTW'(SQ_STEPS - 1));
  assign stat_o.erase_now  = erase_now;
  assign stat_o.sqrt_done  = (cnt_q == CNTW'(SQRT_STEPS - 1));
  assign stat_o.out_free   = !out_valid_q || !out_stall_i;

endmodule

// ===== src/hand_landmark_gesture_tracker_unit.sv =====
// Hand landmark gesture tracker. A frame is 21 landmark items (func 0, the
// final one with last set) or a single no-hand or extraction-failed item.
// Each landmark item passes the states accept, store read, weighted sum, and
// divide and write, paced by the sequencer. The final landmark adds a finish
// pass: a sweep of the point store, six squared-distance steps on one shared
// multiplier, a gesture decision, COORD_BITS+1 square-root steps for a fist,
// then the search-region step and the result load. No-hand and failed items
// pass only the search-region step and the result load. The result load waits
// while the previous result is still held in the output register; the next
// item is taken while a result waits there. Configuration must be written
// only while the block is idle; the block itself does not enforce this.
module hand_landmark_gesture_tracker_unit
  import hlgt_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [CFG_IDX_W-1:0]          cfg_index_i,
  input  logic [CFG_DATA_W-1:0]         cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [1:0]                    func_i,
  input  logic [POINT_IDX_W-1:0]        point_index_i,
  input  logic signed [COORD_BITS-1:0]  point_x_i,
  input  logic signed [COORD_BITS-1:0]  point_y_i,
  input  logic                          last_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic                          hand_detected_o,
  output logic                          painting_o,
  output logic                          erasing_o,
  output logic [FINGER_W-1:0]           finger_count_o,
  output logic signed [COORD_BITS-1:0]  eraser_x_o,
  output logic signed [COORD_BITS-1:0]  eraser_y_o,
  output logic [RADIUS_W-1:0]           eraser_radius_o,
  output logic                          track_valid_o,
  output logic [DIM_W-1:0]              search_x_o,
  output logic [DIM_W-1:0]              search_y_o,
  output logic [DIM_W-1:0]              search_w_o,
  output logic [DIM_W-1:0]              search_h_o
);

  cmd_t  cmd;
  stat_t stat;

  hlgt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .func_i     (func_i),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  hlgt_dpath #(
    .COORD_BITS (COORD_BITS)
  ) u_dpath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .point_index_i   (point_index_i),
    .point_x_i       (point_x_i),
    .point_y_i       (point_y_i),
    .last_i          (last_i),
    .cmd_i           (cmd),
    .stat_o          (stat),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .hand_detected_o (hand_detected_o),
    .painting_o      (painting_o),
    .erasing_o       (erasing_o),
    .finger_count_o  (finger_count_o),
    .eraser_x_o      (eraser_x_o),
    .eraser_y_o      (eraser_y_o),
    .eraser_radius_o (eraser_radius_o),
    .track_valid_o   (track_valid_o),
    .search_x_o      (search_x_o),
    .search_y_o      (search_y_o),
    .search_w_o      (search_w_o),
    .search_h_o      (search_h_o)
  );

endmodule

// ===== test/tb_hand_landmark_gesture_tracker_unit.sv =====
module tb_hand_landmark_gesture_tracker_unit;
  import hlgt_pkg::*;

  localparam int CB        = 14;
  localparam int CYCLE_CAP = 400000;

  typedef struct packed {
    logic            det;
    logic            paint;
    logic            erase;
    logic [2:0]      fingers;
    logic [CB-1:0]   ex;
    logic [CB-1:0]   ey;
    logic [13:0]     radius;
    logic            tv;
    logic [11:0]     sx;
    logic [11:0]     sy;
    logic [11:0]     sw;
    logic [11:0]     sh;
  } gesture_t;

  typedef struct {
    func_e                 f;
    logic [4:0]            idx;
    logic signed [CB-1:0]  x;
    logic signed [CB-1:0]  y;
    logic                  lst;
    bit                    typed;
    gesture_t              res;
  } row_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;
  logic                 in_valid_i = 1'b0;
  logic                 in_stall_o;
  logic [1:0]           func_i = '0;
  logic [4:0]           point_index_i = '0;
  logic signed [CB-1:0] point_x_i = '0;
  logic signed [CB-1:0] point_y_i = '0;
  logic                 last_i = 1'b0;
  logic                 out_valid_o;
  logic                 out_stall_i = 1'b0;
  logic                 hand_detected_o, painting_o, erasing_o, track_valid_o;
  logic [2:0]           finger_count_o;
  logic signed [CB-1:0] eraser_x_o, eraser_y_o;
  logic [13:0]          eraser_radius_o;
  logic [11:0]          search_x_o, search_y_o, search_w_o, search_h_o;

  hand_landmark_gesture_tracker_unit #(.COORD_BITS(CB)) dut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Tracker state mirrored for prediction
  int       cfg_w = 640, cfg_h = 480, cfg_wt = 3, cfg_lim = 3, cfg_span = 20;
  int       sm_x[NUM_POINTS], sm_y[NUM_POINTS];
  bit       sm_ok[NUM_POINTS];
  int       misses = 0;
  bit       tracked = 0, paint_on = 0, erase_on = 0, box_ok = 0;
  int       fingers_up = 0, centre_x = 0, centre_y = 0, radius_held = 0;
  int       box[4] = '{0, 0, 0, 0};

  gesture_t gestures_due[$];
  int       fails = 0;
  int       cycles = 0;
  bit       calm = 0;
  bit       drv_typed = 0;
  gesture_t drv_res = '0;
  int       stall_left = 0;

  function automatic int pt_x(int i);
    return sm_ok[i] ? sm_x[i] : 0;
  endfunction

  function automatic int pt_y(int i);
    return sm_ok[i] ? sm_y[i] : 0;
  endfunction

  function automatic longint sq_dist(int a, int b);
    longint dx, dy;
    dx = pt_x(a) - pt_x(b);
    dy = pt_y(a) - pt_y(b);
    return dx * dx + dy * dy;
  endfunction

  function automatic longint int_sqrt(longint d);
    longint r, b;
    r = 0;
    b = 64'sd1 <<< 40;
    while (b > d) b = b >>> 2;
    while (b != 0) begin
      if (d >= r + b) begin
        d = d - (r + b);
        r = (r >>> 1) + b;
      end else begin
        r = r >>> 1;
      end
      b = b >>> 2;
    end
    return r;
  endfunction

  function automatic int imin(int a, int b);
    return a < b ? a : b;
  endfunction

  function automatic int imax(int a, int b);
    return a > b ? a : b;
  endfunction

  function automatic void drop_track();
    tracked = 0; paint_on = 0; erase_on = 0; box_ok = 0;
    foreach (sm_ok[i]) sm_ok[i] = 0;
  endfunction

  function automatic void finish_hand();
    int  mnx, mxx, mny, mxy, tx, ty, n;
    bit  up, down3;
    n = 0;
    misses = 0;
    if (25 * sq_dist(4, 2) > 16 * sq_dist(3, 2)) n++;
    up = pt_y(8) < pt_y(6);
    if (up) n++;
    if (pt_y(12) < pt_y(10)) n++;
    if (pt_y(16) < pt_y(14)) n++;
    if (pt_y(20) < pt_y(18)) n++;
    fingers_up = n;
    down3 = pt_y(12) > pt_y(10) && pt_y(16) > pt_y(14) && pt_y(20) > pt_y(18);
    paint_on = up && down3;
    erase_on = !up && down3;
    if (erase_on) begin
      centre_x = pt_x(9);
      centre_y = pt_y(9);
      radius_held = int'(imin(16383, int'(int_sqrt(sq_dist(0, 9)) / 2)));
    end else begin
      radius_held = 0;
    end
    tracked = 1;
    mnx = cfg_w; mxx = 0; mny = cfg_h; mxy = 0;
    for (int i = 0; i < NUM_POINTS; i++) begin
      if (sm_ok[i]) begin
        tx = imax(0, imin(cfg_w - 1, sm_x[i]));
        ty = imax(0, imin(cfg_h - 1, sm_y[i]));
        mnx = imin(mnx, tx); mxx = imax(mxx, tx);
        mny = imin(mny, ty); mxy = imax(mxy, ty);
      end
    end
    if (mxx > mnx && mxy > mny && (mxx - mnx) > cfg_span) begin
      box[0] = mnx; box[1] = mny; box[2] = mxx - mnx; box[3] = mxy - mny;
      box_ok = 1;
    end else begin
      box_ok = 0;
    end
  endfunction

  function automatic gesture_t report();
    gesture_t g;
    int padx, pady, sx, sy;
    g = '0;
    g.det = tracked;
    g.paint = tracked && paint_on;
    g.erase = tracked && erase_on;
    g.fingers = fingers_up[2:0];
    g.ex = centre_x[CB-1:0];
    g.ey = centre_y[CB-1:0];
    g.radius = g.erase ? radius_held[13:0] : 14'd0;
    g.tv = box_ok && box[2] > 0;
    if (g.tv) begin
      padx = box[2] * 4 / 5;
      pady = box[3] * 4 / 5;
      sx = imax(0, box[0] - padx);
      sy = imax(0, box[1] - pady);
      g.sx = sx[11:0];
      g.sy = sy[11:0];
      g.sw = 12'(imax(0, imin(cfg_w - sx, box[2] + 2 * padx)));
      g.sh = 12'(imax(0, imin(cfg_h - sy, box[3] + 2 * pady)));
    end
    return g;
  endfunction

  // Advance the mirrored tracker by one item; returns 1 when a result is due
  function automatic bit track_item(logic [1:0] f, logic [4:0] idx,
                                    logic signed [CB-1:0] x, logic signed [CB-1:0] y,
                                    logic lst, output gesture_t g);
    int w;
    w = cfg_wt > 10 ? 10 : cfg_wt;
    g = '0;
    case (f)
      FUNC_POINT: begin
        if (idx < NUM_POINTS) begin
          if (misses != 0 || !sm_ok[idx]) begin
            sm_x[idx] = x;
            sm_y[idx] = y;
          end else begin
            sm_x[idx] = (w * sm_x[idx] + (10 - w) * int'(x)) / 10;
            sm_y[idx] = (w * sm_y[idx] + (10 - w) * int'(y)) / 10;
          end
          sm_ok[idx] = 1;
        end
        if (!lst) return 0;
        finish_hand();
      end
      FUNC_NO_HAND: drop_track();
      FUNC_FAILED: begin
        if (misses < 255) misses++;
        if (misses > cfg_lim) drop_track();
      end
      default: return 0;
    endcase
    g = report();
    return 1;
  endfunction

  // Predict on every accepted item
  always @(posedge clk_i) begin
    gesture_t g;
    if (rst_ni && in_valid_i && !in_stall_o) begin
      if (track_item(func_i, point_index_i, point_x_i, point_y_i, last_i, g))
        gestures_due = {gestures_due, (drv_typed ? drv_res : g)};
    end
  end

  // Check every accepted result against the oldest prediction
  always @(posedge clk_i) begin
    gesture_t e;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (gestures_due.size() == 0) begin
        $error("unexpected result item");
        fails++;
      end else begin
        e = gestures_due.pop_front();
        if (hand_detected_o !== e.det) begin
          $error("hand_detected exp %0d got %0d", e.det, hand_detected_o); fails++;
        end
        if (painting_o !== e.paint) begin
          $error("painting exp %0d got %0d", e.paint, painting_o); fails++;
        end
        if (erasing_o !== e.erase) begin
          $error("erasing exp %0d got %0d", e.erase, erasing_o); fails++;
        end
        if (finger_count_o !== e.fingers) begin
          $error("finger_count exp %0d got %0d", e.fingers, finger_count_o); fails++;
        end
        if (eraser_x_o !== e.ex) begin
          $error("eraser_x exp %0d got %0d", $signed(e.ex), eraser_x_o); fails++;
        end
        if (eraser_y_o !== e.ey) begin
          $error("eraser_y exp %0d got %0d", $signed(e.ey), eraser_y_o); fails++;
        end
        if (eraser_radius_o !== e.radius) begin
          $error("eraser_radius exp %0d got %0d", e.radius, eraser_radius_o); fails++;
        end
        if (track_valid_o !== e.tv) begin
          $error("track_valid exp %0d got %0d", e.tv, track_valid_o); fails++;
        end
        if (search_x_o !== e.sx) begin
          $error("search_x exp %0d got %0d", e.sx, search_x_o); fails++;
        end
        if (search_y_o !== e.sy) begin
          $error("search_y exp %0d got %0d", e.sy, search_y_o); fails++;
        end
        if (search_w_o !== e.sw) begin
          $error("search_w exp %0d got %0d", e.sw, search_w_o); fails++;
        end
        if (search_h_o !== e.sh) begin
          $error("search_h exp %0d got %0d", e.sh, search_h_o); fails++;
        end
      end
    end
  end

  // Stall the result side in random bursts
  always @(negedge clk_i) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_stall_i <= 1'b1;
    end else if (!calm && $urandom_range(0, 5) == 0) begin
      stall_left <= $urandom_range(0, 13);
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  // Bound the run
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_CAP) begin
      $display("FAIL hand_landmark_gesture_tracker_unit");
      $finish;
    end
  end

  // Drive one item from a falling edge and hold it until accepted
  task automatic send(logic [1:0] f, logic [4:0] idx, logic signed [CB-1:0] x,
                      logic signed [CB-1:0] y, logic lst, bit typed = 0,
                      gesture_t res = '0);
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 14)) @(negedge clk_i);
    end
    func_i <= f; point_index_i <= idx; point_x_i <= x; point_y_i <= y;
    last_i <= lst; drv_typed <= typed; drv_res <= res;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    @(negedge clk_i);
  endtask

  // Hold off until every result is in and the finish pass has drained
  task automatic drain();
    in_valid_i <= 1'b0;
    while (gestures_due.size() != 0) @(negedge clk_i);
    repeat (80) @(negedge clk_i);
  endtask

  task automatic write_cfg(logic [CFG_IDX_W-1:0] ri, int v);
    cfg_we_i <= 1'b1; cfg_index_i <= ri; cfg_data_i <= v[11:0];
    case (ri)
      CFG_FRAME_W:  cfg_w = v & 12'hFFF;
      CFG_FRAME_H:  cfg_h = v & 12'hFFF;
      CFG_WEIGHT:   cfg_wt = v & 4'hF;
      CFG_MISS_LIM: cfg_lim = v & 8'hFF;
      CFG_MIN_SPAN: cfg_span = v & 12'hFFF;
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Send a hand frame near (cx,cy); a wide spread lets off-screen points in
  task automatic hand_frame(int cx, int cy, int spread, ref int sent);
    int x, y;
    for (int i = 0; i < NUM_POINTS; i++) begin
      x = cx + $urandom_range(0, 2 * spread) - spread;
      y = cy + $urandom_range(0, 2 * spread) - spread;
      x = imax(-8192, imin(8191, x));
      y = imax(-8192, imin(8191, y));
      send(FUNC_POINT, i[4:0], x[CB-1:0], y[CB-1:0], i == NUM_POINTS - 1);
      sent++;
    end
  endtask

  task automatic random_phase(int quota);
    int sent, n, kind;
    sent = 0;
    while (sent < quota) begin
      kind = $urandom_range(0, 11);
      if (kind <= 5) begin
        hand_frame($urandom_range(0, cfg_w), $urandom_range(0, cfg_h),
                   $urandom_range(5, 150), sent);
      end else if (kind == 6) begin
        hand_frame(0, 0, 8192, sent);
      end else if (kind == 7) begin
        send(FUNC_NO_HAND, 5'($urandom), 14'($urandom), 14'($urandom), 1'($urandom));
        sent++;
      end else if (kind == 8) begin
        n = $urandom_range(1, 6);
        repeat (n) begin
          send(FUNC_FAILED, 5'($urandom), 14'($urandom), 14'($urandom), 1'($urandom));
          sent++;
        end
      end else if (kind == 9) begin
        send(FUNC_UNUSED, 5'($urandom), 14'($urandom), 14'($urandom), 1'($urandom));
        send(FUNC_POINT, 5'($urandom_range(NUM_POINTS, 31)), 14'($urandom),
             14'($urandom), 1'($urandom));
      end else begin
        // broken frame: random indexes, cut short
        n = $urandom_range(1, 12);
        for (int k = 0; k < n; k++) begin
          send(FUNC_POINT, 5'($urandom_range(0, 31)), 14'($urandom), 14'($urandom),
               k == n - 1);
          sent++;
        end
      end
    end
  endtask

  row_t plan[$];

  initial begin
    row_t r;
    int   v;
    for (int i = 0; i < NUM_POINTS; i++) begin
      sm_x[i] = 0; sm_y[i] = 0; sm_ok[i] = 0;
    end
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed table: reset results are all zero, then an extreme frame
    r = '{FUNC_NO_HAND, 5'd0, 14'sd0, 14'sd0, 1'b0, 1, '0};
    plan = {plan, r};
    r = '{FUNC_FAILED, 5'd31, 14'sd0, 14'sd0, 1'b1, 1, '0};
    plan = {plan, r};
    r = '{FUNC_UNUSED, 5'd0, 14'sd0, 14'sd0, 1'b1, 0, '0};
    plan = {plan, r};
    r = '{FUNC_POINT, 5'd31, 14'sh1FFF, 14'sh2000, 1'b0, 0, '0};
    plan = {plan, r};
    for (int i = 0; i < NUM_POINTS; i++) begin
      case (i % 4)
        0: v = -8192;
        1: v = 8191;
        2: v = 0;
        default: v = 37 * i;
      endcase
      r = '{FUNC_POINT, i[4:0], v[CB-1:0], 14'(300 - 11 * i), i == NUM_POINTS - 1, 0, '0};
      plan = {plan, r};
    end
    foreach (plan[i])
      send(plan[i].f, plan[i].idx, plan[i].x, plan[i].y, plan[i].lst,
           plan[i].typed, plan[i].res);

    // Random phases under several settings, extremes included
    random_phase(120);
    drain();
    write_cfg(CFG_FRAME_W, 4095); write_cfg(CFG_FRAME_H, 4095);
    write_cfg(CFG_WEIGHT, 0); write_cfg(CFG_MISS_LIM, 0); write_cfg(CFG_MIN_SPAN, 0);
    random_phase(110);
    drain();
    write_cfg(CFG_FRAME_W, 1); write_cfg(CFG_FRAME_H, 1);
    write_cfg(CFG_WEIGHT, 15); write_cfg(CFG_MISS_LIM, 255);
    write_cfg(CFG_MIN_SPAN, 4095);
    send(FUNC_FAILED, 5'd0, 14'sd0, 14'sd0, 1'b1);
    random_phase(60);
    drain();
    write_cfg(CFG_FRAME_W, 800); write_cfg(CFG_FRAME_H, 600);
    write_cfg(CFG_WEIGHT, 10); write_cfg(CFG_MISS_LIM, 2); write_cfg(CFG_MIN_SPAN, 5);
    random_phase(110);
    drain();
    // shrink the frame under a held box
    write_cfg(CFG_FRAME_W, 50); write_cfg(CFG_FRAME_H, 40);
    write_cfg(CFG_WEIGHT, 7); write_cfg(CFG_MISS_LIM, 1);
    send(FUNC_FAILED, 5'd0, 14'sd0, 14'sd0, 1'b0);
    calm = 1;
    random_phase(80);

    in_valid_i <= 1'b0;
    while (gestures_due.size() != 0) @(negedge clk_i);
    repeat (100) @(negedge clk_i);
    if (fails == 0) begin
      $display("PASS hand_landmark_gesture_tracker_unit");
    end else begin
      $display("FAIL hand_landmark_gesture_tracker_unit");
    end
    $finish;
  end

endmodule
